[rtl/lcd_pkg.sv]
// Shared types, codes and constants of the lane-change decision block.
package lcd_pkg;

  // Field widths of the input, squaring-stage and configuration words.
  localparam int unsigned S_W       = 17;
  localparam int unsigned D_W       = 13;
  localparam int unsigned SPD_W     = 11;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned V_W       = 12;
  localparam int unsigned SQ_W      = 23;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 3;

  // Item kinds.
  localparam logic ACT_EGO = 1'b0;
  localparam logic ACT_CAR = 1'b1;

  // Planner mode codes.
  localparam logic [2:0] MODE_STARTUP = 3'd0;
  localparam logic [2:0] MODE_KEEP    = 3'd1;
  localparam logic [2:0] MODE_PREP    = 3'd2;
  localparam logic [2:0] MODE_CHG_L   = 3'd3;
  localparam logic [2:0] MODE_CHG_R   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_GAP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_GAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAVY_GAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REAR_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REAR_MID   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REAR_LOW   = 3'd7;

  // Fixed-point constants (speeds 1/16 mph, d in 1/256 m).
  localparam logic [ID_W-1:0]  NO_CAR        = 8'd255;
  localparam logic [1:0]       NO_LANE       = 2'd3;
  localparam logic [11:0]      FASTER_MARGIN = 12'd48;
  localparam logic [10:0]      HIGH_SPEED    = 11'd640;
  localparam logic [10:0]      MID_SPEED     = 11'd528;
  localparam logic [9:0]       HALF_LANE     = 10'h200;
  localparam logic signed [13:0] CENTER_TOL  = 14'sd256;
  localparam logic signed [12:0] MOVE_STEP   = 13'sd16;
  localparam logic signed [12:0] SPEED_MAX   = 13'sd2047;
  localparam logic [SQ_W-1:0]  SQ_MAX        = 23'h7FFFFF;

  // Configuration register file contents.
  typedef struct packed {
    logic [10:0]      cruise_speed;
    logic [7:0]       startup_delta;
    logic [CFG_W-1:0] front_gap;
    logic [CFG_W-1:0] slow_gap;
    logic [CFG_W-1:0] heavy_slow_gap;
    logic [CFG_W-1:0] rear_gap_high;
    logic [CFG_W-1:0] rear_gap_mid;
    logic [CFG_W-1:0] rear_gap_low;
  } cfg_t;

  // Word handed from the squaring stage to the decision core.
  typedef struct packed {
    logic                  action;
    logic [S_W-1:0]        pos_s;
    logic signed [D_W-1:0] pos_d;
    logic [SPD_W-1:0]      ego_speed;
    logic [ID_W-1:0]       car_id;
    logic                  last;
    logic [SQ_W-1:0]       sq0;
    logic [SQ_W-1:0]       sq1;
  } sq_word_t;

  // Lane of a lateral offset: below 4 m lane 0, below 8 m lane 1, else lane 2.
  function automatic logic [1:0] lane_of(input logic signed [D_W-1:0] d);
    logic [1:0] lane;
    if (d[D_W-1] || (d[D_W-2:D_W-3] == 2'b00)) begin
      lane = 2'd0;
    end else if (!d[D_W-2]) begin
      lane = 2'd1;
    end else begin
      lane = 2'd2;
    end
    return lane;
  endfunction

endpackage

[rtl/lcd_if.sv]
// Valid/ready channel interfaces for input words and result words.
interface lcd_in_if import lcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [S_W-1:0]        pos_s;
  logic signed [D_W-1:0] pos_d;
  logic [SPD_W-1:0]      ego_speed;
  logic [ID_W-1:0]       car_id;
  logic signed [V_W-1:0] vel_x;
  logic signed [V_W-1:0] vel_y;
  logic                  last;

  modport source (output valid, action, pos_s, pos_d, ego_speed, car_id, vel_x, vel_y, last,
                  input ready);
  modport sink   (input valid, action, pos_s, pos_d, ego_speed, car_id, vel_x, vel_y, last,
                  output ready);
endinterface

interface lcd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         plan_state;
  logic [1:0]         plan_lane;
  logic signed [11:0] plan_speed;
  logic [1:0]         smooth_factor;
  logic [7:0]         ahead_id;

  modport source (output valid, plan_state, plan_lane, plan_speed, smooth_factor, ahead_id,
                  input ready);
  modport sink   (input valid, plan_state, plan_lane, plan_speed, smooth_factor, ahead_id,
                  output ready);
endinterface

[rtl/lane_change_decision_fsm_top.sv]
// Top level of the lane-change decision block.
// The block takes one word per clock cycle, ego and vehicle words alike. A
// frame-closing word passes through the input register, while the squaring
// logic forms the velocity squares (or the ego speed squares), and then the
// squaring-stage register, while the decision core updates the frame state
// and loads the result register. Throughput drops only while a result waits in
// the result register and the next word also closes a frame. Configuration
// writes take effect on the next cycle.
module lane_change_decision_fsm_top import lcd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  lcd_in_if.sink               in_i,
  lcd_out_if.source            out_o
);

  cfg_t     cfg;
  sq_word_t sq_word;
  logic     sq_valid, core_ready;

  // Configuration registers.
  lcd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register and squaring stage.
  lcd_sq u_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .word_o  (sq_word),
    .valid_o (sq_valid),
    .ready_i (core_ready)
  );

  // Decision core and result register.
  lcd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .word_i  (sq_word),
    .valid_i (sq_valid),
    .ready_o (core_ready),
    .out_o   (out_o)
  );

endmodule

[rtl/lcd_cfg.sv]
// Configuration register file with its write port.
module lcd_cfg import lcd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  // Register writes decoded by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_speed   <= 11'd720;
      cfg_q.startup_delta  <= 8'd48;
      cfg_q.front_gap      <= 12'd640;
      cfg_q.slow_gap       <= 12'd560;
      cfg_q.heavy_slow_gap <= 12'd320;
      cfg_q.rear_gap_high  <= 12'd320;
      cfg_q.rear_gap_mid   <= 12'd560;
      cfg_q.rear_gap_low   <= 12'd800;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CRUISE:    cfg_q.cruise_speed   <= cfg_data_i[10:0];
        CFG_STARTUP:   cfg_q.startup_delta  <= cfg_data_i[7:0];
        CFG_FRONT_GAP: cfg_q.front_gap      <= cfg_data_i;
        CFG_SLOW_GAP:  cfg_q.slow_gap       <= cfg_data_i;
        CFG_HEAVY_GAP: cfg_q.heavy_slow_gap <= cfg_data_i;
        CFG_REAR_HIGH: cfg_q.rear_gap_high  <= cfg_data_i;
        CFG_REAR_MID:  cfg_q.rear_gap_mid   <= cfg_data_i;
        CFG_REAR_LOW:  cfg_q.rear_gap_low   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/lcd_sq.sv]
// Input register and squaring stage: two squares per word, registered for the core.
module lcd_sq import lcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcd_in_if.sink    in_i,
  output sq_word_t  word_o,
  output logic      valid_o,
  input  logic      ready_i
);

  typedef struct packed {
    logic                  action;
    logic [S_W-1:0]        pos_s;
    logic signed [D_W-1:0] pos_d;
    logic [SPD_W-1:0]      ego_speed;
    logic [ID_W-1:0]       car_id;
    logic signed [V_W-1:0] vel_x;
    logic signed [V_W-1:0] vel_y;
    logic                  last;
  } in_word_t;

  logic     a_valid_q, b_valid_q;
  in_word_t a_q;
  sq_word_t b_q, b_d;
  logic     b_free, a_adv;
  logic [V_W-1:0]        lim;
  logic signed [V_W:0]   op0, op1;
  logic signed [2*V_W+1:0] prod0, prod1;

  // Handshake between the two stages and the core.
  assign b_free     = !b_valid_q || ready_i;
  assign a_adv      = a_valid_q && b_free;
  assign in_i.ready = !a_valid_q || a_adv;
  assign valid_o    = b_valid_q;
  assign word_o     = b_q;

  // Vehicle words square the velocity components; ego words square the
  // ego speed and the ego speed plus the faster-car margin.
  always_comb begin
    lim = {1'b0, a_q.ego_speed} + FASTER_MARGIN;
    if (a_q.action == ACT_CAR) begin
      op0 = {a_q.vel_x[V_W-1], a_q.vel_x};
      op1 = {a_q.vel_y[V_W-1], a_q.vel_y};
    end else begin
      op0 = $signed({2'b00, a_q.ego_speed});
      op1 = $signed({1'b0, lim});
    end
    prod0 = $signed({{(V_W+1){op0[V_W]}}, op0}) * $signed({{(V_W+1){op0[V_W]}}, op0});
    prod1 = $signed({{(V_W+1){op1[V_W]}}, op1}) * $signed({{(V_W+1){op1[V_W]}}, op1});
    b_d.action    = a_q.action;
    b_d.pos_s     = a_q.pos_s;
    b_d.pos_d     = a_q.pos_d;
    b_d.ego_speed = a_q.ego_speed;
    b_d.car_id    = a_q.car_id;
    b_d.last      = a_q.last;
    b_d.sq0       = prod0[SQ_W-1:0];
    b_d.sq1       = prod1[SQ_W-1:0];
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) a_valid_q <= in_i.valid;
      if (b_free)     b_valid_q <= a_valid_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      a_q.action    <= in_i.action;
      a_q.pos_s     <= in_i.pos_s;
      a_q.pos_d     <= in_i.pos_d;
      a_q.ego_speed <= in_i.ego_speed;
      a_q.car_id    <= in_i.car_id;
      a_q.vel_x     <= in_i.vel_x;
      a_q.vel_y     <= in_i.vel_y;
      a_q.last      <= in_i.last;
    end
    if (a_adv) b_q <= b_d;
  end

endmodule

[rtl/lcd_core.sv]
// Decision core: frame state, vehicle classification, mode update and result register.
module lcd_core import lcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  sq_word_t  word_i,
  input  logic      valid_i,
  output logic      ready_o,
  lcd_out_if.source out_o
);

  typedef struct packed {
    logic [2:0]         plan_state;
    logic [1:0]         plan_lane;
    logic signed [11:0] plan_speed;
    logic [1:0]         smooth_factor;
    logic [7:0]         ahead_id;
  } res_t;

  // Planner state.
  logic [2:0]            mode_q, mode_n;
  logic [ID_W-1:0]       lead_id_q, lead_id_n;
  logic [1:0]            goal_q, goal_n;
  logic [S_W-1:0]        frame_s_q;
  logic signed [D_W-1:0] frame_d_q;
  logic [SPD_W-1:0]      frame_speed_q;
  logic [SQ_W-1:0]       frame_sq_q, frame_lim_sq_q;
  logic                  trig_q, trig_n;
  logic [S_W-1:0]        lead_s_q, lead_s_n;
  logic [SQ_W-1:0]       lead_sq_q, lead_sq_n;
  logic [1:0]            side_q, side_n;

  logic o_valid_q, o_take, fire, is_ego;
  res_t o_q, res;

  logic [S_W-1:0]        eff_s;
  logic signed [D_W-1:0] eff_d;
  logic [SPD_W-1:0]      eff_speed;
  logic [SQ_W-1:0]       eff_sq, eff_lim, vsq;
  logic [SQ_W:0]         vsq_sum;
  logic [1:0]            ego_lane, car_lane;
  logic                  ahead, front, rear, faster, changing;
  logic [CFG_W-1:0]      need;
  logic [S_W-1:0]        fwd_dist, back_dist;
  logic signed [13:0]    diff;
  logic signed [S_W:0]   gap;
  logic signed [12:0]    spd_x, cruise_x, spd;

  // Result register handshake; a frame-closing word waits for room.
  assign o_take  = o_valid_q && out_o.ready;
  assign ready_o = !word_i.last || !o_valid_q || o_take;
  assign fire    = valid_i && ready_o;

  // Vehicle classification and frame-end decision.
  always_comb begin
    is_ego    = (word_i.action == ACT_EGO);
    eff_s     = is_ego ? word_i.pos_s     : frame_s_q;
    eff_d     = is_ego ? word_i.pos_d     : frame_d_q;
    eff_speed = is_ego ? word_i.ego_speed : frame_speed_q;
    eff_sq    = is_ego ? word_i.sq0       : frame_sq_q;
    eff_lim   = is_ego ? word_i.sq1       : frame_lim_sq_q;

    vsq_sum = {1'b0, word_i.sq0} + {1'b0, word_i.sq1};
    vsq     = vsq_sum[SQ_W] ? SQ_MAX : vsq_sum[SQ_W-1:0];

    ego_lane  = lane_of(eff_d);
    car_lane  = lane_of(word_i.pos_d);
    ahead     = word_i.pos_s > eff_s;
    fwd_dist  = word_i.pos_s - eff_s;
    back_dist = eff_s - word_i.pos_s;
    front     = ahead && (fwd_dist < {5'b0, cfg_i.front_gap}) && (vsq <= eff_lim);
    if (eff_speed >= HIGH_SPEED) begin
      need = cfg_i.rear_gap_high;
    end else if (eff_speed >= MID_SPEED) begin
      need = cfg_i.rear_gap_mid;
    end else begin
      need = cfg_i.rear_gap_low;
    end
    rear = !ahead && (back_dist < {5'b0, need});

    // Per-word state update.
    trig_n    = trig_q;
    side_n    = side_q;
    lead_id_n = lead_id_q;
    lead_s_n  = lead_s_q;
    lead_sq_n = lead_sq_q;
    if (is_ego) begin
      trig_n = 1'b0;
      side_n = 2'b00;
    end else begin
      case (mode_q)
        MODE_KEEP: begin
          if (!trig_q && (car_lane == ego_lane) && front) begin
            trig_n    = 1'b1;
            lead_id_n = word_i.car_id;
            lead_s_n  = word_i.pos_s;
            lead_sq_n = vsq;
          end
        end
        MODE_PREP: begin
          if (word_i.car_id == lead_id_q) begin
            lead_s_n  = word_i.pos_s;
            lead_sq_n = vsq;
          end
          if (front || rear) begin
            if ((ego_lane != 2'd0) && (car_lane == ego_lane - 2'd1)) side_n[0] = 1'b1;
            if ((ego_lane != 2'd2) && (car_lane == ego_lane + 2'd1)) side_n[1] = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Mode transition at frame end.
    mode_n = mode_q;
    goal_n = goal_q;
    diff   = $signed({eff_d[D_W-1], eff_d}) - $signed({2'b00, goal_q, HALF_LANE});
    unique case (mode_q)
      MODE_STARTUP: begin
        if (eff_speed >= cfg_i.cruise_speed) mode_n = MODE_KEEP;
      end
      MODE_KEEP: begin
        if (trig_n) mode_n = MODE_PREP;
      end
      MODE_PREP: begin
        if ((ego_lane != 2'd0) && !side_n[0]) begin
          mode_n = MODE_CHG_L;
          goal_n = ego_lane - 2'd1;
        end else if ((ego_lane != 2'd2) && !side_n[1]) begin
          mode_n = MODE_CHG_R;
          goal_n = ego_lane + 2'd1;
        end
      end
      MODE_CHG_L, MODE_CHG_R: begin
        if ((diff > -CENTER_TOL) && (diff < CENTER_TOL)) mode_n = MODE_KEEP;
      end
      default: ;
    endcase

    // Planned speed for the new mode, saturated at the top.
    spd_x    = $signed({2'b00, eff_speed});
    cruise_x = $signed({2'b00, cfg_i.cruise_speed});
    gap      = $signed({1'b0, lead_s_n}) - $signed({1'b0, eff_s});
    faster   = eff_sq > lead_sq_n;
    if (mode_n == MODE_STARTUP) begin
      spd = spd_x + $signed({5'b0, cfg_i.startup_delta});
    end else if (mode_n == MODE_PREP) begin
      if ((gap < $signed({6'b0, cfg_i.heavy_slow_gap})) && faster) begin
        spd = spd_x - (MOVE_STEP <<< 1);
      end else if ((gap < $signed({6'b0, cfg_i.slow_gap})) && faster) begin
        spd = spd_x - MOVE_STEP;
      end else if ((gap > $signed({6'b0, cfg_i.heavy_slow_gap})) &&
                   (eff_speed < cfg_i.cruise_speed)) begin
        spd = spd_x + MOVE_STEP;
      end else begin
        spd = cruise_x;
      end
    end else if (eff_speed < cfg_i.cruise_speed) begin
      spd = spd_x + (MOVE_STEP <<< 1);
    end else begin
      spd = cruise_x;
    end
    if (spd > SPEED_MAX) spd = SPEED_MAX;

    changing          = (mode_n == MODE_CHG_L) || (mode_n == MODE_CHG_R);
    res.plan_state    = mode_n;
    res.plan_lane     = changing ? goal_n : ego_lane;
    res.plan_speed    = spd[11:0];
    res.smooth_factor = changing ? 2'd2 : 2'd1;
    res.ahead_id      = lead_id_n;
  end

  // Frame and planner state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_STARTUP;
      lead_id_q      <= NO_CAR;
      goal_q         <= NO_LANE;
      frame_s_q      <= '0;
      frame_d_q      <= '0;
      frame_speed_q  <= '0;
      frame_sq_q     <= '0;
      frame_lim_sq_q <= SQ_W'({12'd0, FASTER_MARGIN} * {12'd0, FASTER_MARGIN});
      trig_q         <= 1'b0;
      lead_s_q       <= '0;
      lead_sq_q      <= '0;
      side_q         <= 2'b00;
    end else if (fire) begin
      if (is_ego) begin
        frame_s_q      <= word_i.pos_s;
        frame_d_q      <= word_i.pos_d;
        frame_speed_q  <= word_i.ego_speed;
        frame_sq_q     <= word_i.sq0;
        frame_lim_sq_q <= word_i.sq1;
      end
      trig_q    <= trig_n;
      side_q    <= side_n;
      lead_id_q <= lead_id_n;
      lead_s_q  <= lead_s_n;
      lead_sq_q <= lead_sq_n;
      if (word_i.last) begin
        mode_q <= mode_n;
        goal_q <= goal_n;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (fire && word_i.last) begin
      o_valid_q <= 1'b1;
    end else if (o_take) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && word_i.last) o_q <= res;
  end

  assign out_o.valid         = o_valid_q;
  assign out_o.plan_state    = o_q.plan_state;
  assign out_o.plan_lane     = o_q.plan_lane;
  assign out_o.plan_speed    = o_q.plan_speed;
  assign out_o.smooth_factor = o_q.smooth_factor;
  assign out_o.ahead_id      = o_q.ahead_id;

  // A word that does not close a frame never changes the result valid flag while no result is taken.
  a_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !word_i.last && !o_take) |=> (o_valid_q == $past(o_valid_q)))
    else $error("result appeared for a word that does not close a frame");

  // A frame-closing word is only taken when the result register has room.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && word_i.last) |-> (!o_valid_q || o_take))
    else $error("pending result overwritten");

  // The mode never leaves the defined codes.
  a_mode_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q <= MODE_CHG_R))
    else $error("mode holds an unused code");

  // In the change modes a target lane has been chosen.
  a_goal_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mode_q == MODE_CHG_L) || (mode_q == MODE_CHG_R)) |-> (goal_q != NO_LANE))
    else $error("change mode without target lane");

  // An ego word restarts the frame flags.
  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_ego) |=> (!trig_q && (side_q == 2'b00)))
    else $error("frame flags not cleared by ego word");

endmodule
